>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the I2C byte master sequencer
// Concurrent checks, clocked and reset-qualified; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset
`define I2CBMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds at a rising clock edge outside reset
`define I2CBMS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define I2CBMS_ASSERT(lbl, clk, rstn, prop)
`define I2CBMS_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> hdl/i2cbms_pkg.sv
// ----------------------------------------------------------------------------
// i2cbms_pkg
// Types and constants shared by the I2C byte master sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cbms_pkg;

  // Command codes carried in the kind field
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  // Phase length after reset, in ticks
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd2;
  // Bits per transferred byte
  localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

  // One input item
  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] address;
    logic       rw;
    logic [7:0] data;
    logic       last;
    logic       sda_in;
  } i2cbms_in_t;

  // One result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_input_mode;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_ok;
    logic       rejected;
  } i2cbms_out_t;

endpackage

`default_nettype wire

>>> hdl/i2cbms_core.sv
// ----------------------------------------------------------------------------
// i2cbms_core
// Bus sequencing state and the single-pass next-state logic; updates on
// every accepted item and produces that item's result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2cbms_core
  import i2cbms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        accept_i,
  input  wire i2cbms_in_t  item_i,
  output i2cbms_out_t      res_o
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_WLOW   = 4'd2,
    PH_WHIGH  = 4'd3,
    PH_ALOW   = 4'd4,
    PH_AHIGH  = 4'd5,
    PH_RHIGH  = 4'd6,
    PH_RLOW   = 4'd7,
    PH_RALOW  = 4'd8,
    PH_RAHIGH = 4'd9,
    PH_STOPA  = 4'd10,
    PH_STOPB  = 4'd11,
    PH_STOPC  = 4'd12
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] wait_q, wait_d;
  logic        ack_q, ack_d;
  logic        nak_q, nak_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        rel_q, rel_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] ticks_q;

  logic [15:0] limit;
  logic [16:0] wait_inc;
  logic        over;
  logic [15:0] wait_adv;
  logic [3:0]  bit_inc;
  logic        is_cmd;
  logic        busy;
  logic        done;
  logic        rej;

  // Phase timer: zero length counts as one tick
  assign limit    = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
  assign wait_inc = {1'b0, wait_q} + 17'd1;
  assign over     = (wait_inc >= {1'b0, limit});
  assign wait_adv = over ? 16'd0 : wait_inc[15:0];
  assign bit_inc  = bit_q + 4'd1;

  assign is_cmd = (item_i.kind == KIND_START) || (item_i.kind == KIND_WRITE) ||
                  (item_i.kind == KIND_READ)  || (item_i.kind == KIND_STOP);
  assign busy   = (phase_q != PH_IDLE);

  // Next state for one item
  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    ack_d   = ack_q;
    nak_d   = nak_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rel_d   = rel_q;
    hold_d  = hold_q;
    done    = 1'b0;
    rej     = 1'b0;

    if (accept_i) begin
      if (is_cmd && busy) begin
        // drop the command, keep the running sequence
        rej = 1'b1;
      end else if (is_cmd) begin
        bit_d  = 4'd0;
        wait_d = 16'd0;
        unique case (item_i.kind)
          KIND_START: begin
            shift_d = {item_i.address, item_i.rw};
            rel_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_START;
          end
          KIND_WRITE: begin
            shift_d = item_i.data;
            rel_d   = 1'b0;
            sda_d   = item_i.data[7];
            scl_d   = 1'b1;
            phase_d = PH_WHIGH;
          end
          KIND_READ: begin
            shift_d = 8'd0;
            nak_d   = item_i.last;
            rel_d   = 1'b1;
            sda_d   = 1'b1;
            scl_d   = 1'b1;
            phase_d = PH_RHIGH;
          end
          default: begin
            // stop
            rel_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_STOPA;
          end
        endcase
      end else if (busy) begin
        unique case (phase_q)
          PH_START: begin
            wait_d = wait_adv;
            if (over) begin
              scl_d   = 1'b0;
              phase_d = PH_WLOW;
            end
          end
          PH_WLOW: begin
            // drive next bit with SCL rising
            rel_d   = 1'b0;
            sda_d   = shift_q[7];
            scl_d   = 1'b1;
            wait_d  = 16'd0;
            phase_d = PH_WHIGH;
          end
          PH_WHIGH: begin
            wait_d = wait_adv;
            if (over) begin
              scl_d   = 1'b0;
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_inc;
              phase_d = (bit_inc >= BITS_PER_BYTE) ? PH_ALOW : PH_WLOW;
            end
          end
          PH_ALOW: begin
            rel_d   = 1'b1;
            sda_d   = 1'b1;
            scl_d   = 1'b1;
            wait_d  = 16'd0;
            phase_d = PH_AHIGH;
          end
          PH_AHIGH: begin
            wait_d = wait_adv;
            if (over) begin
              ack_d   = ~item_i.sda_in;
              scl_d   = 1'b0;
              rel_d   = 1'b0;
              sda_d   = 1'b0;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          PH_RHIGH: begin
            wait_d = wait_adv;
            if (over) begin
              shift_d = {shift_q[6:0], item_i.sda_in};
              scl_d   = 1'b0;
              bit_d   = bit_inc;
              phase_d = (bit_inc >= BITS_PER_BYTE) ? PH_RALOW : PH_RLOW;
            end
          end
          PH_RLOW: begin
            scl_d   = 1'b1;
            wait_d  = 16'd0;
            phase_d = PH_RHIGH;
          end
          PH_RALOW: begin
            hold_d  = shift_q;
            rel_d   = 1'b0;
            sda_d   = nak_q;
            scl_d   = 1'b1;
            wait_d  = 16'd0;
            phase_d = PH_RAHIGH;
          end
          PH_RAHIGH: begin
            wait_d = wait_adv;
            if (over) begin
              scl_d   = 1'b0;
              sda_d   = 1'b0;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          PH_STOPA: begin
            wait_d = wait_adv;
            if (over) begin
              scl_d   = 1'b1;
              phase_d = PH_STOPB;
            end
          end
          PH_STOPB: begin
            wait_d = wait_adv;
            if (over) begin
              sda_d   = 1'b1;
              phase_d = PH_STOPC;
            end
          end
          PH_STOPC: begin
            wait_d = wait_adv;
            if (over) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result of this item: state after the update
  always_comb begin
    res_o.scl_out        = scl_d;
    res_o.sda_out        = sda_d;
    res_o.sda_input_mode = rel_d;
    res_o.busy_res       = (phase_d != PH_IDLE);
    res_o.done_res       = done;
    res_o.read_data      = hold_d;
    res_o.ack_ok         = ack_d;
    res_o.rejected       = rej;
  end

  // Hold sequencer state and the phase length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      wait_q  <= 16'd0;
      ack_q   <= 1'b0;
      nak_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      rel_q   <= 1'b0;
      hold_q  <= 8'd0;
      ticks_q <= PHASE_TICKS_RESET;
    end else begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      ack_q   <= ack_d;
      nak_q   <= nak_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rel_q   <= rel_d;
      hold_q  <= hold_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
    end
  end

  `I2CBMS_ASSERT(a_reject_holds_phase, clk_i, rst_ni, accept_i && rej |=> $stable(phase_q))
  `I2CBMS_ASSERT(a_done_goes_idle, clk_i, rst_ni, accept_i && done |=> phase_q == PH_IDLE)
  `I2CBMS_ASSERT(a_released_sda_high, clk_i, rst_ni, rel_q |-> sda_q)
  `I2CBMS_NEVER(a_bit_count_range, clk_i, rst_ni, bit_q > BITS_PER_BYTE)

endmodule

`default_nettype wire

>>> hdl/i2cbms_out_stage.sv
// ----------------------------------------------------------------------------
// i2cbms_out_stage
// Result register with valid flag; frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2cbms_out_stage
  import i2cbms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire i2cbms_out_t res_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output i2cbms_out_t      out_data_o
);

  logic        valid_q;
  i2cbms_out_t data_q;

  // Room for a new result when empty or being drained this cycle
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Track the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  `I2CBMS_NEVER(a_no_overwrite, clk_i, rst_ni, load_i && valid_q && !out_ready_i)
  `I2CBMS_ASSERT(a_load_sets_valid, clk_i, rst_ni, load_i |=> valid_q)
  `I2CBMS_ASSERT(a_drain_clears, clk_i, rst_ni, valid_q && out_ready_i && !load_i |=> !valid_q)

endmodule

`default_nettype wire

>>> hdl/i2cbms_top.sv
// ----------------------------------------------------------------------------
// i2c_byte_master_sequencer_top
// I2C byte-level master paced by tick items: start, write, read, stop.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one item per
//   transfer: a tick that advances the running command, or a start, write,
//   read or stop command. Output channel (out_valid_o / out_ready_i /
//   out_data_o) returns exactly one result per item: the SCL/SDA levels,
//   busy/done flags, last read byte, acknowledge and a reject flag.
//   cfg_we_i/cfg_wdata_i set the ticks per SCL-high or settle phase; write
//   it only while idle.
//   Result: registered; it appears in the cycle after its item is accepted.
//   Throughput: one item per cycle; the next state is computed in one pass
//   from the accepted item and the state registers into the result register.
//   Reset: lines high, SDA driven, idle, phase length 2, result register empty.
//   Stall: while the result register holds an untaken result, a new item is
//   accepted only in the cycle the receiver takes it; otherwise in_ready_o
//   stays low and the sequencer holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_byte_master_sequencer_top
  import i2cbms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire i2cbms_in_t  in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output i2cbms_out_t      out_data_o
);

  logic        space;
  logic        accept;
  i2cbms_out_t res;

  // Accept a transfer when the result register can take its result
  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  i2cbms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .res_o       (res)
  );

  i2cbms_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for i2c_byte_master_sequencer_top
// Drives tick and command items over a valid/ready channel and checks every
// result against an in-bench prediction of the SCL/SDA sequencing. Covers
// idle items, bare commands, full start/write/read/stop transactions, rejects
// while busy, phase length extremes and a mid-phase change, random traffic
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import i2cbms_pkg::*;

  // Sequencer phases of the predictor
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_WR_LOW,
    SEQ_WR_HIGH,
    SEQ_ACK_LOW,
    SEQ_ACK_HIGH,
    SEQ_RD_HIGH,
    SEQ_RD_LOW,
    SEQ_RACK_LOW,
    SEQ_RACK_HIGH,
    SEQ_STOP_A,
    SEQ_STOP_B,
    SEQ_STOP_C
  } seq_phase_e;

  // How the slave side drives SDA on tick items
  typedef enum logic [1:0] {
    SDA_LOW,
    SDA_HIGH,
    SDA_RAND
  } sda_drive_e;

  localparam int RAND_ITEMS  = 1500;
  localparam int HOLD_CYCLES = 200;
  localparam int CFG_PERIOD  = 250;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  i2cbms_in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  i2cbms_out_t out_data;

  // Predictor state
  seq_phase_e  mdl_phase;
  logic [3:0]  mdl_bits;
  logic [7:0]  mdl_shift;
  logic [15:0] mdl_wait;
  logic        mdl_ack;
  logic        mdl_nak;
  logic        mdl_scl;
  logic        mdl_sda;
  logic        mdl_rel;
  logic [7:0]  mdl_rd_hold;
  logic [15:0] mdl_len;

  i2cbms_out_t expected_results[$];

  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int rejects       = 0;
  int settings_used = 0;
  bit no_idle       = 1'b0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  i2c_byte_master_sequencer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void reset_model();
    mdl_phase   = SEQ_IDLE;
    mdl_bits    = '0;
    mdl_shift   = '0;
    mdl_wait    = '0;
    mdl_ack     = 1'b0;
    mdl_nak     = 1'b0;
    mdl_scl     = 1'b1;
    mdl_sda     = 1'b1;
    mdl_rel     = 1'b0;
    mdl_rd_hold = '0;
    mdl_len     = PHASE_TICKS_RESET;
  endfunction

  // Count one tick of a timed phase; a length of zero acts as one
  function automatic bit phase_elapsed();
    logic [16:0] limit;
    logic [16:0] next;
    limit = (mdl_len == 16'd0) ? 17'd1 : {1'b0, mdl_len};
    next  = {1'b0, mdl_wait} + 17'd1;
    if (next >= limit) begin
      mdl_wait = '0;
      return 1'b1;
    end
    mdl_wait = next[15:0];
    return 1'b0;
  endfunction

  // Put the next MSB on SDA and raise SCL
  function automatic void drive_data_bit();
    mdl_rel   = 1'b0;
    mdl_sda   = mdl_shift[7];
    mdl_scl   = 1'b1;
    mdl_wait  = '0;
    mdl_phase = SEQ_WR_HIGH;
  endfunction

  // Advance the running command by one tick; return 1 when it completes
  function automatic bit advance_sequence(logic sda_in);
    bit fin;
    fin = 1'b0;
    case (mdl_phase)
      SEQ_START: begin
        if (phase_elapsed()) begin
          mdl_scl   = 1'b0;
          mdl_phase = SEQ_WR_LOW;
        end
      end
      SEQ_WR_LOW: drive_data_bit();
      SEQ_WR_HIGH: begin
        if (phase_elapsed()) begin
          mdl_scl   = 1'b0;
          mdl_shift = mdl_shift << 1;
          mdl_bits  = mdl_bits + 4'd1;
          mdl_phase = (mdl_bits >= BITS_PER_BYTE) ? SEQ_ACK_LOW : SEQ_WR_LOW;
        end
      end
      SEQ_ACK_LOW: begin
        mdl_rel   = 1'b1;
        mdl_sda   = 1'b1;
        mdl_scl   = 1'b1;
        mdl_wait  = '0;
        mdl_phase = SEQ_ACK_HIGH;
      end
      SEQ_ACK_HIGH: begin
        if (phase_elapsed()) begin
          mdl_ack   = ~sda_in;
          mdl_scl   = 1'b0;
          mdl_rel   = 1'b0;
          mdl_sda   = 1'b0;
          mdl_phase = SEQ_IDLE;
          fin       = 1'b1;
        end
      end
      SEQ_RD_HIGH: begin
        if (phase_elapsed()) begin
          mdl_shift = {mdl_shift[6:0], sda_in};
          mdl_scl   = 1'b0;
          mdl_bits  = mdl_bits + 4'd1;
          mdl_phase = (mdl_bits >= BITS_PER_BYTE) ? SEQ_RACK_LOW : SEQ_RD_LOW;
        end
      end
      SEQ_RD_LOW: begin
        mdl_scl   = 1'b1;
        mdl_wait  = '0;
        mdl_phase = SEQ_RD_HIGH;
      end
      SEQ_RACK_LOW: begin
        mdl_rd_hold = mdl_shift;
        mdl_rel     = 1'b0;
        mdl_sda     = mdl_nak;
        mdl_scl     = 1'b1;
        mdl_wait    = '0;
        mdl_phase   = SEQ_RACK_HIGH;
      end
      SEQ_RACK_HIGH: begin
        if (phase_elapsed()) begin
          mdl_scl   = 1'b0;
          mdl_sda   = 1'b0;
          mdl_phase = SEQ_IDLE;
          fin       = 1'b1;
        end
      end
      SEQ_STOP_A: begin
        if (phase_elapsed()) begin
          mdl_scl   = 1'b1;
          mdl_phase = SEQ_STOP_B;
        end
      end
      SEQ_STOP_B: begin
        if (phase_elapsed()) begin
          mdl_sda   = 1'b1;
          mdl_phase = SEQ_STOP_C;
        end
      end
      SEQ_STOP_C: begin
        if (phase_elapsed()) begin
          mdl_phase = SEQ_IDLE;
          fin       = 1'b1;
        end
      end
      default: mdl_phase = SEQ_IDLE;
    endcase
    return fin;
  endfunction

  // Apply one accepted item and return the result it produces
  function automatic i2cbms_out_t predict_result(i2cbms_in_t it);
    i2cbms_out_t res;
    bit          is_cmd;
    bit          was_busy;
    bit          fin;
    bit          rej;
    is_cmd   = (it.kind >= KIND_START) && (it.kind <= KIND_STOP);
    was_busy = (mdl_phase != SEQ_IDLE);
    fin      = 1'b0;
    rej      = 1'b0;
    if (is_cmd && was_busy) begin
      rej = 1'b1;
    end else if (is_cmd) begin
      mdl_bits = '0;
      mdl_wait = '0;
      case (it.kind)
        KIND_START: begin
          mdl_shift = {it.address, it.rw};
          mdl_rel   = 1'b0;
          mdl_sda   = 1'b0;
          mdl_phase = SEQ_START;
        end
        KIND_WRITE: begin
          mdl_shift = it.data;
          drive_data_bit();
        end
        KIND_READ: begin
          mdl_shift = '0;
          mdl_nak   = it.last;
          mdl_rel   = 1'b1;
          mdl_sda   = 1'b1;
          mdl_scl   = 1'b1;
          mdl_phase = SEQ_RD_HIGH;
        end
        default: begin
          mdl_rel   = 1'b0;
          mdl_sda   = 1'b0;
          mdl_phase = SEQ_STOP_A;
        end
      endcase
    end else if (was_busy) begin
      fin = advance_sequence(it.sda_in);
    end
    res.scl_out        = mdl_scl;
    res.sda_out        = mdl_sda;
    res.sda_input_mode = mdl_rel;
    res.busy_res       = (mdl_phase != SEQ_IDLE);
    res.done_res       = fin;
    res.read_data      = mdl_rd_hold;
    res.ack_ok         = mdl_ack;
    res.rejected       = rej;
    if (rej) rejects++;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Channel handling
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    if (errors <= 50) begin
      $display("[%0t] MISMATCH result %0d %s: got %h, expected %h",
               $time, results_seen, what, got, want);
    end
  endtask

  // Offer one item, hold it until the transfer, then record its expectation
  task automatic send_item(i2cbms_in_t it);
    bit ok;
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    expected_results.push_back(predict_result(it));
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_phase_ticks(logic [15:0] ticks);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_len   = ticks;
    settings_used++;
  endtask

  function automatic i2cbms_in_t make_item(logic [2:0] kind);
    logic [31:0] r;
    i2cbms_in_t  it;
    r       = $urandom;
    it      = r[$bits(i2cbms_in_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  function automatic i2cbms_in_t cmd_item(logic [2:0] kind, logic [6:0] addr, logic rw,
                                          logic [7:0] data, logic last);
    i2cbms_in_t it;
    it         = make_item(kind);
    it.address = addr;
    it.rw      = rw;
    it.data    = data;
    it.last    = last;
    return it;
  endfunction

  // Tick until the running command is done; noise mixes in other kinds
  task automatic finish_command(sda_drive_e mode, int noise_pct);
    i2cbms_in_t it;
    while (mdl_phase != SEQ_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) it = make_item(3'($urandom_range(1, 7)));
      else it = make_item(KIND_TICK);
      case (mode)
        SDA_LOW:  it.sda_in = 1'b0;
        SDA_HIGH: it.sda_in = 1'b1;
        default:  it.sda_in = $urandom_range(0, 1);
      endcase
      send_item(it);
    end
  endtask

  task automatic run_command(i2cbms_in_t cmd, sda_drive_e mode, int noise_pct);
    send_item(cmd);
    finish_command(mode, noise_pct);
  endtask

  // Start, zero to three bytes in the direction of rw, then stop
  task automatic random_transaction(int noise_pct);
    logic rw;
    int   n;
    rw = $urandom_range(0, 1);
    n  = $urandom_range(0, 3);
    run_command(cmd_item(KIND_START, 7'($urandom), rw, 8'h00, 1'b0), SDA_RAND, noise_pct);
    for (int i = 0; i < n; i++) begin
      if (rw) begin
        run_command(cmd_item(KIND_READ, 7'h00, 1'b0, 8'h00, (i == n - 1)),
                    SDA_RAND, noise_pct);
      end else begin
        run_command(cmd_item(KIND_WRITE, 7'h00, 1'b0, 8'($urandom), 1'b0),
                    SDA_RAND, noise_pct);
      end
    end
    run_command(cmd_item(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), SDA_RAND, noise_pct);
  endtask

  // --------------------------------------------------------------------------
  // Receiver and result checking
  // --------------------------------------------------------------------------

  // Take results with random stalls, a requested hold-off, or none at all
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 15);
    end
  end

  // Compare each transferred result with the oldest expectation
  always @(negedge clk) begin
    i2cbms_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 8'h00, 8'h00);
      end else begin
        want = expected_results.pop_front();
        if (out_data.scl_out !== want.scl_out)
          report_mismatch("scl_out", out_data.scl_out, want.scl_out);
        if (out_data.sda_out !== want.sda_out)
          report_mismatch("sda_out", out_data.sda_out, want.sda_out);
        if (out_data.sda_input_mode !== want.sda_input_mode)
          report_mismatch("sda_input_mode", out_data.sda_input_mode, want.sda_input_mode);
        if (out_data.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_data.busy_res, want.busy_res);
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", out_data.done_res, want.done_res);
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.ack_ok !== want.ack_ok)
          report_mismatch("ack_ok", out_data.ack_ok, want.ack_ok);
        if (out_data.rejected !== want.rejected)
          report_mismatch("rejected", out_data.rejected, want.rejected);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Ticks and unused kinds while idle change nothing
  task automatic test_idle_items();
    i2cbms_in_t it;
    it = '0;
    send_item(it);
    it      = '1;
    it.kind = KIND_TICK;
    send_item(it);
    it = '1;
    send_item(it);
    send_item(make_item(3'd5));
    send_item(make_item(3'd6));
  endtask

  // Commands with no start, from the reset line levels
  task automatic test_bare_commands();
    run_command(cmd_item(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), SDA_RAND, 0);
    run_command(cmd_item(KIND_WRITE, 7'h00, 1'b0, 8'hA5, 1'b0), SDA_LOW, 0);
    run_command(cmd_item(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b0), SDA_RAND, 0);
  endtask

  // Full transactions with extreme addresses, bytes and both acknowledges
  task automatic test_transactions();
    run_command(cmd_item(KIND_START, 7'h7F, 1'b0, 8'h00, 1'b0), SDA_LOW, 0);
    run_command(cmd_item(KIND_WRITE, 7'h00, 1'b0, 8'h00, 1'b0), SDA_HIGH, 0);
    run_command(cmd_item(KIND_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0), SDA_LOW, 0);
    run_command(cmd_item(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), SDA_RAND, 0);
    run_command(cmd_item(KIND_START, 7'h00, 1'b1, 8'h00, 1'b0), SDA_HIGH, 0);
    run_command(cmd_item(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b0), SDA_HIGH, 0);
    run_command(cmd_item(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b1), SDA_LOW, 0);
    run_command(cmd_item(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), SDA_RAND, 0);
  endtask

  // Every kind arriving mid-command: commands rejected, unused kinds tick
  task automatic test_busy_rejects();
    send_item(cmd_item(KIND_START, 7'h55, 1'b1, 8'h00, 1'b0));
    for (int k = 1; k <= 7; k++) begin
      send_item(make_item(3'(k)));
      send_item(make_item(KIND_TICK));
    end
    finish_command(SDA_RAND, 0);
  endtask

  // Phase length zero, one, the maximum, and a change in the middle of a phase
  task automatic test_phase_extremes();
    set_phase_ticks(16'd0);
    run_command(cmd_item(KIND_START, 7'h2A, 1'b0, 8'h00, 1'b0), SDA_RAND, 0);
    run_command(cmd_item(KIND_WRITE, 7'h00, 1'b0, 8'h3C, 1'b0), SDA_RAND, 0);
    set_phase_ticks(16'd1);
    run_command(cmd_item(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b1), SDA_RAND, 0);
    run_command(cmd_item(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), SDA_RAND, 0);
    set_phase_ticks(16'hFFFF);
    send_item(cmd_item(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0));
    repeat (40) send_item(make_item(KIND_TICK));
    // shrink the length while the settle phase is running
    set_phase_ticks(16'd3);
    finish_command(SDA_RAND, 0);
    set_phase_ticks(PHASE_TICKS_RESET);
  endtask

  // Mostly well-formed transactions, some bare commands and some noise
  task automatic test_random_traffic();
    int base;
    int period_base;
    int period;
    int pick;
    base        = items_sent;
    period_base = items_sent;
    period      = 0;
    while (items_sent - base < RAND_ITEMS) begin
      if (items_sent - period_base >= CFG_PERIOD) begin
        period++;
        period_base = items_sent;
        case ($urandom_range(0, 5))
          0:       set_phase_ticks(16'd1);
          1:       set_phase_ticks(16'd2);
          2:       set_phase_ticks(16'd3);
          3:       set_phase_ticks(16'd0);
          default: set_phase_ticks(16'($urandom_range(1, 8)));
        endcase
        // one period runs with neither side idling
        no_idle = (period == 2);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        random_transaction(5);
      end else if (pick < 85) begin
        run_command(make_item(3'($urandom_range(1, 4))), SDA_RAND, 5);
      end else begin
        repeat ($urandom_range(1, 5)) send_item(make_item(3'($urandom_range(0, 7))));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off long enough that the block fills and stalls input
  task automatic test_backpressure();
    wait_drained();
    hold_requests++;
    random_transaction(0);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_items();
    test_bare_commands();
    test_transactions();
    test_busy_rejects();
    test_phase_extremes();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (5) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("expected results never arrived", 8'(expected_results.size()), 8'h00);
    end

    $display("Summary: %0d items sent, %0d results checked, %0d commands rejected.",
             items_sent, results_seen, rejects);
    $display("Summary: %0d phase length writes incl. 0, 1, 65535 and a mid-phase change.",
             settings_used);
    if (errors == 0) begin
      $display("i2c_byte_master_sequencer_top test passed");
    end else begin
      $display("i2c_byte_master_sequencer_top test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("i2c_byte_master_sequencer_top test failed");
    $finish;
  end

endmodule
